>>> design/pvtp_pkg.sv
// Shared types, widths and codes of the polygon vertex table.
package pvtp_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 64;

  localparam int unsigned ACT_W   = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned COORD_W = 16;
  localparam int unsigned STS_W   = 2;
  localparam int unsigned PER_W   = 24;
  localparam int unsigned CNTO_W  = 7;

  localparam int unsigned DIFF_W = COORD_W + 1;
  localparam int unsigned SQ_W   = 2 * DIFF_W;
  localparam int unsigned ROOT_W = SQ_W / 2;
  localparam int unsigned REM_W  = ROOT_W + 4;

  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 3'd0,
    ACT_REMOVE = 3'd1,
    ACT_SET    = 3'd2,
    ACT_GET    = 3'd3,
    ACT_PERIM  = 3'd4
  } action_e;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_BAD_POS = 2'd1,
    STS_FULL    = 2'd2,
    STS_EMPTY   = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_REM_RD,
    S_REM_WR,
    S_SET,
    S_GET_RD,
    S_GET_LAT,
    S_PER_RD,
    S_PER_LAT,
    S_PER_DIFF,
    S_PER_SQ,
    S_PER_SUM,
    S_PER_ROOT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_res_t;

endpackage

>>> design/pvtp_in_if.sv
// Request channel of the polygon vertex table.
interface pvtp_in_if;
  logic                                valid;
  logic                                ready;
  logic [pvtp_pkg::ACT_W-1:0]          action;
  logic [pvtp_pkg::POS_W-1:0]          position;
  logic signed [pvtp_pkg::COORD_W-1:0] coord_x;
  logic signed [pvtp_pkg::COORD_W-1:0] coord_y;

  modport source (output valid, action, position, coord_x, coord_y, input ready);
  modport sink   (input valid, action, position, coord_x, coord_y, output ready);
endinterface

>>> design/pvtp_out_if.sv
// Response channel of the polygon vertex table.
interface pvtp_out_if;
  logic                                valid;
  logic                                ready;
  logic [pvtp_pkg::STS_W-1:0]          status;
  logic signed [pvtp_pkg::COORD_W-1:0] read_x;
  logic signed [pvtp_pkg::COORD_W-1:0] read_y;
  logic [pvtp_pkg::PER_W-1:0]          perimeter;
  logic [pvtp_pkg::CNTO_W-1:0]         vertex_count;
  logic [pvtp_pkg::CNTO_W-1:0]         side_count;

  modport source (output valid, status, read_x, read_y, perimeter, vertex_count, side_count,
                  input ready);
  modport sink   (input valid, status, read_x, read_y, perimeter, vertex_count, side_count,
                  output ready);
endinterface

>>> design/pvtp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pvtp_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/pvtp_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module pvtp_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pvtp_pkg::SQ_W-1:0]   value_i,
  output pvtp_pkg::sqrt_res_t         res_o
);

  localparam int unsigned CW = $clog2(pvtp_pkg::ROOT_W + 1);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [CW-1:0]                 cnt_q, cnt_d;
  logic [pvtp_pkg::SQ_W-1:0]     val_q, val_d;
  logic [pvtp_pkg::REM_W-1:0]    rem_q, rem_d;
  logic [pvtp_pkg::ROOT_W-1:0]   root_q, root_d;
  logic [pvtp_pkg::REM_W-1:0]    rem_sh;
  logic [pvtp_pkg::REM_W-1:0]    trial;

  always_comb begin
    rem_sh = {rem_q[pvtp_pkg::REM_W-3:0], val_q[pvtp_pkg::SQ_W-1 -: 2]};
    trial  = pvtp_pkg::REM_W'({root_q, 2'b01});
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(pvtp_pkg::ROOT_W);
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
    end else if (busy_q) begin
      val_d = {val_q[pvtp_pkg::SQ_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[pvtp_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[pvtp_pkg::ROOT_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign res_o.done = done_q;
  assign res_o.root = root_q;

endmodule

>>> design/polygon_vertex_table_perimeter_core.sv
// Polygon vertex table: insert, remove, set, get and closed-ring perimeter.
// Error and no-op requests go straight to the response; insert and remove shift the
// vertices one at a time, with a read and a write for each. Perimeter runs the 17-step
// iterative square root once per edge of the closed ring.
// One request at a time; reset empties the table (vertex contents stay undefined).
module polygon_vertex_table_perimeter_core #(
  parameter int unsigned MAX_VERTICES = pvtp_pkg::MAX_VERTICES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pvtp_in_if.sink     req_i,
  pvtp_out_if.source  rsp_o
);

  localparam int unsigned IDX_W = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CMP_W = ((CNT_W > pvtp_pkg::POS_W) ? CNT_W : pvtp_pkg::POS_W) + 1;
  localparam int unsigned ENT_W = 2 * pvtp_pkg::COORD_W;
  localparam int unsigned OSUM_W = pvtp_pkg::PER_W + 1;

  pvtp_pkg::state_e state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;

  logic [pvtp_pkg::ACT_W-1:0]   act_q, act_d;
  logic [CMP_W-1:0]             pos0_q, pos0_d;
  logic [ENT_W-1:0]             new_q, new_d;
  pvtp_pkg::status_e            sts_q, sts_d;
  logic [ENT_W-1:0]             rdv_q, rdv_d;
  logic [pvtp_pkg::PER_W-1:0]   acc_q, acc_d;
  logic [ENT_W-1:0]             first_q, first_d;
  logic [ENT_W-1:0]             prev_q, prev_d;
  logic [ENT_W-1:0]             cur_q, cur_d;
  logic signed [pvtp_pkg::DIFF_W-1:0] dx_q, dx_d, dy_q, dy_d;
  logic [pvtp_pkg::SQ_W-1:0]    sqx_q, sqx_d, sqy_q, sqy_d;

  logic [pvtp_pkg::STS_W-1:0]   o_sts_q, o_sts_d;
  logic [ENT_W-1:0]             o_rd_q, o_rd_d;
  logic [pvtp_pkg::PER_W-1:0]   o_per_q, o_per_d;
  logic [pvtp_pkg::CNTO_W-1:0]  o_cnt_q, o_cnt_d, o_side_q, o_side_d;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ENT_W-1:0] ram_wdata, ram_rdata;

  logic                        sq_start;
  logic [pvtp_pkg::SQ_W-1:0]   sq_value;
  pvtp_pkg::sqrt_res_t         sq_res;

  logic [CMP_W-1:0]   posw, cntw;
  logic               accept;
  logic [OSUM_W-1:0]  acc_sum;
  logic signed [pvtp_pkg::SQ_W-1:0] sqx_full, sqy_full;

  pvtp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_VERTICES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pvtp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .value_i (sq_value),
    .res_o   (sq_res)
  );

  assign req_i.ready = (state_q == pvtp_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign posw        = CMP_W'(req_i.position);
  assign cntw        = CMP_W'(count_q);
  assign acc_sum     = OSUM_W'(acc_q) + OSUM_W'(sq_res.root);
  assign sqx_full    = pvtp_pkg::SQ_W'(dx_q) * pvtp_pkg::SQ_W'(dx_q);
  assign sqy_full    = pvtp_pkg::SQ_W'(dy_q) * pvtp_pkg::SQ_W'(dy_q);
  assign sq_value    = sqx_q + sqy_q;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    act_d       = act_q;
    pos0_d      = pos0_q;
    new_d       = new_q;
    sts_d       = sts_q;
    rdv_d       = rdv_q;
    acc_d       = acc_q;
    first_d     = first_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    o_sts_d     = o_sts_q;
    o_rd_d      = o_rd_q;
    o_per_d     = o_per_q;
    o_cnt_d     = o_cnt_q;
    o_side_d    = o_side_q;
    ram_we      = 1'b0;
    ram_waddr   = idx_q[IDX_W-1:0];
    ram_wdata   = ram_rdata;
    ram_raddr   = idx_q[IDX_W-1:0];
    sq_start    = 1'b0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      pvtp_pkg::S_IDLE: begin
        if (accept) begin
          act_d  = req_i.action;
          pos0_d = posw - CMP_W'(1);
          new_d  = {req_i.coord_x, req_i.coord_y};
          sts_d  = pvtp_pkg::STS_OK;
          rdv_d  = '0;
          acc_d  = '0;
          state_d = pvtp_pkg::S_DONE;
          priority case (req_i.action)
            pvtp_pkg::ACT_INSERT: begin
              if (cntw == CMP_W'(MAX_VERTICES)) begin
                sts_d = pvtp_pkg::STS_FULL;
              end else if (posw == '0 || posw > cntw + CMP_W'(1)) begin
                sts_d = pvtp_pkg::STS_BAD_POS;
              end else begin
                idx_d   = count_q;
                state_d = pvtp_pkg::S_INS_RD;
              end
            end
            pvtp_pkg::ACT_REMOVE, pvtp_pkg::ACT_SET, pvtp_pkg::ACT_GET: begin
              if (posw == '0 || posw > cntw) begin
                sts_d = pvtp_pkg::STS_BAD_POS;
              end else begin
                idx_d = CNT_W'(posw - CMP_W'(1));
                priority case (req_i.action)
                  pvtp_pkg::ACT_REMOVE: state_d = pvtp_pkg::S_REM_RD;
                  pvtp_pkg::ACT_SET:    state_d = pvtp_pkg::S_SET;
                  default:              state_d = pvtp_pkg::S_GET_RD;
                endcase
              end
            end
            pvtp_pkg::ACT_PERIM: begin
              if (count_q == '0) begin
                sts_d = pvtp_pkg::STS_EMPTY;
              end else begin
                idx_d   = '0;
                state_d = pvtp_pkg::S_PER_RD;
              end
            end
            default: ;
          endcase
        end
      end

      pvtp_pkg::S_INS_RD: begin
        if (CMP_W'(idx_q) == pos0_q) begin
          ram_we    = 1'b1;
          ram_wdata = new_q;
          count_d   = count_q + CNT_W'(1);
          state_d   = pvtp_pkg::S_DONE;
        end else begin
          ram_raddr = IDX_W'(idx_q - CNT_W'(1));
          state_d   = pvtp_pkg::S_INS_WR;
        end
      end

      pvtp_pkg::S_INS_WR: begin
        // move the entry below up by one
        ram_we  = 1'b1;
        idx_d   = idx_q - CNT_W'(1);
        state_d = pvtp_pkg::S_INS_RD;
      end

      pvtp_pkg::S_REM_RD: begin
        if (idx_q + CNT_W'(1) >= count_q) begin
          count_d = count_q - CNT_W'(1);
          state_d = pvtp_pkg::S_DONE;
        end else begin
          ram_raddr = IDX_W'(idx_q + CNT_W'(1));
          state_d   = pvtp_pkg::S_REM_WR;
        end
      end

      pvtp_pkg::S_REM_WR: begin
        ram_we  = 1'b1;
        idx_d   = idx_q + CNT_W'(1);
        state_d = pvtp_pkg::S_REM_RD;
      end

      pvtp_pkg::S_SET: begin
        ram_we    = 1'b1;
        ram_wdata = new_q;
        state_d   = pvtp_pkg::S_DONE;
      end

      pvtp_pkg::S_GET_RD: begin
        state_d = pvtp_pkg::S_GET_LAT;
      end

      pvtp_pkg::S_GET_LAT: begin
        rdv_d   = ram_rdata;
        state_d = pvtp_pkg::S_DONE;
      end

      pvtp_pkg::S_PER_RD: begin
        state_d = pvtp_pkg::S_PER_LAT;
      end

      pvtp_pkg::S_PER_LAT: begin
        if (idx_q == '0) begin
          first_d = ram_rdata;
          prev_d  = ram_rdata;
          if (count_q == CNT_W'(1)) begin
            cur_d   = ram_rdata;
            last_d  = 1'b1;
            state_d = pvtp_pkg::S_PER_DIFF;
          end else begin
            idx_d   = CNT_W'(1);
            state_d = pvtp_pkg::S_PER_RD;
          end
        end else begin
          cur_d   = ram_rdata;
          last_d  = 1'b0;
          state_d = pvtp_pkg::S_PER_DIFF;
        end
      end

      pvtp_pkg::S_PER_DIFF: begin
        dx_d = $signed({prev_q[ENT_W-1], prev_q[ENT_W-1 -: pvtp_pkg::COORD_W]})
             - $signed({cur_q[ENT_W-1], cur_q[ENT_W-1 -: pvtp_pkg::COORD_W]});
        dy_d = $signed({prev_q[pvtp_pkg::COORD_W-1], prev_q[pvtp_pkg::COORD_W-1:0]})
             - $signed({cur_q[pvtp_pkg::COORD_W-1], cur_q[pvtp_pkg::COORD_W-1:0]});
        prev_d  = cur_q;
        state_d = pvtp_pkg::S_PER_SQ;
      end

      pvtp_pkg::S_PER_SQ: begin
        sqx_d   = sqx_full;
        sqy_d   = sqy_full;
        state_d = pvtp_pkg::S_PER_SUM;
      end

      pvtp_pkg::S_PER_SUM: begin
        sq_start = 1'b1;
        state_d  = pvtp_pkg::S_PER_ROOT;
      end

      pvtp_pkg::S_PER_ROOT: begin
        if (sq_res.done) begin
          // saturate the running sum
          acc_d = acc_sum[OSUM_W-1] ? '1 : acc_sum[pvtp_pkg::PER_W-1:0];
          if (last_q) begin
            state_d = pvtp_pkg::S_DONE;
          end else if (idx_q + CNT_W'(1) == count_q) begin
            cur_d   = first_q;
            last_d  = 1'b1;
            state_d = pvtp_pkg::S_PER_DIFF;
          end else begin
            idx_d   = idx_q + CNT_W'(1);
            state_d = pvtp_pkg::S_PER_RD;
          end
        end
      end

      pvtp_pkg::S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d = 1'b1;
          o_sts_d     = sts_q;
          o_rd_d      = rdv_q;
          o_per_d     = (act_q == pvtp_pkg::ACT_PERIM) ? acc_q : '0;
          o_cnt_d     = pvtp_pkg::CNTO_W'(count_q);
          if (count_q < CNT_W'(2)) begin
            o_side_d = '0;
          end else if (count_q == CNT_W'(2)) begin
            o_side_d = pvtp_pkg::CNTO_W'(1);
          end else begin
            o_side_d = pvtp_pkg::CNTO_W'(count_q);
          end
          state_d = pvtp_pkg::S_IDLE;
        end
      end

      default: state_d = pvtp_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pvtp_pkg::S_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q    <= act_d;
    pos0_q   <= pos0_d;
    new_q    <= new_d;
    sts_q    <= sts_d;
    rdv_q    <= rdv_d;
    acc_q    <= acc_d;
    first_q  <= first_d;
    prev_q   <= prev_d;
    cur_q    <= cur_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    sqx_q    <= sqx_d;
    sqy_q    <= sqy_d;
    o_sts_q  <= o_sts_d;
    o_rd_q   <= o_rd_d;
    o_per_q  <= o_per_d;
    o_cnt_q  <= o_cnt_d;
    o_side_q <= o_side_d;
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = o_sts_q;
  assign rsp_o.read_x       = o_rd_q[ENT_W-1 -: pvtp_pkg::COORD_W];
  assign rsp_o.read_y       = o_rd_q[pvtp_pkg::COORD_W-1:0];
  assign rsp_o.perimeter    = o_per_q;
  assign rsp_o.vertex_count = o_cnt_q;
  assign rsp_o.side_count   = o_side_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_VERTICES))
    else $error("vertex count beyond table depth");

  a_rsp_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == pvtp_pkg::S_DONE))
    else $error("response raised outside completion");

  a_root_in_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_res.done |-> state_q == pvtp_pkg::S_PER_ROOT)
    else $error("square root finished outside perimeter walk");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != $past(count_q) |-> $past(state_q == pvtp_pkg::S_INS_RD)
                                  || $past(state_q == pvtp_pkg::S_REM_RD))
    else $error("vertex count changed outside insert or remove");

endmodule
